@@ rtl/parent_array_tree_size_aggregator_macros.svh @@
// Assertion macros for the parent-array tree size aggregator checker.
// No dependencies.
`ifndef PARENT_ARRAY_TREE_SIZE_AGGREGATOR_MACROS_SVH
`define PARENT_ARRAY_TREE_SIZE_AGGREGATOR_MACROS_SVH

// hold b in the same cycle as a
`define PATSA_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("patsa check failed");

// hold b in the cycle after a
`define PATSA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("patsa check failed");

`endif

@@ rtl/patsa_pkg.sv @@
// Shared types and constants for the parent-array tree size aggregator.
// No dependencies.
`default_nettype none
package patsa_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  parent_index;
    logic [9:0]  read_index;
    logic [63:0] logical_size;
    logic        is_directory;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [9:0]  new_index;
    logic [9:0]  parent_out;
    logic        has_parent;
    logic [9:0]  first_child;
    logic        has_child;
    logic [9:0]  next_sibling;
    logic        has_sibling;
    logic [63:0] size_out;
    logic [10:0] file_count;
    logic [9:0]  directory_count;
    logic        is_dir_out;
  } out_word_t;

  typedef enum logic [1:0] {
    REQ_ROOT, REQ_CHILD, REQ_AGG, REQ_READ
  } req_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_ADD_ROOT, OP_RD_HEAD, OP_ADD, OP_LINK, OP_WALK_ZERO, OP_CLR_RD,
    OP_CLR_WR, OP_SUM_INIT, OP_SUM_RD, OP_SUM_RDP, OP_SUM_WR, OP_RD_NODE
  } op_t;

  typedef enum logic [1:0] {
    RES_REJ, RES_OK, RES_ADD, RES_READ
  } res_t;

  typedef struct packed {
    logic cap;
    op_t  op;
    logic load;
    res_t res;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic count_zero;
    logic full;
    logic par_ok;
    logic idx_ok;
    logic walk_last;
    logic walk_zero;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/patsa_dp.sv @@
// Datapath: node tables, walk counter, request and result registers.
// Depends on patsa_pkg.
`default_nettype none
module patsa_dp (
  input  wire                   clk,
  input  wire                   rst_n,
  input  patsa_pkg::cmd_t       cmd,
  output patsa_pkg::stat_t      st,
  input  patsa_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  wire                   out_ready,
  output patsa_pkg::out_word_t  out_word
);

  localparam int IW = patsa_pkg::IDX_W;
  localparam int CW = patsa_pkg::CNT_W;

  logic [IW-1:0] par_mem   [patsa_pkg::MAX_NODES];
  logic [IW:0]   head_mem  [patsa_pkg::MAX_NODES];
  logic [IW:0]   sib_mem   [patsa_pkg::MAX_NODES];
  logic [63:0]   size_mem  [patsa_pkg::MAX_NODES];
  logic [10:0]   files_mem [patsa_pkg::MAX_NODES];
  logic [9:0]    dirs_mem  [patsa_pkg::MAX_NODES];
  logic          dflag_mem [patsa_pkg::MAX_NODES];

  patsa_pkg::in_word_t  req_r;
  patsa_pkg::out_word_t out_r, out_nxt;
  logic          out_valid_r;
  logic [CW-1:0] count_r, count_nxt, cnt_m1;
  logic [IW-1:0] walk_r, walk_nxt;

  logic [IW-1:0] par_rd;
  logic [IW:0]   head_rd, sib_rd;
  logic [63:0]   size_rd;
  logic [10:0]   files_rd;
  logic [9:0]    dirs_rd;
  logic          dflag_rd;

  logic [IW-1:0] h_par_r;
  logic [63:0]   h_size_r;
  logic [10:0]   h_files_r;
  logic [9:0]    h_dirs_r;
  logic          h_dflag_r;

  logic          rd_en, we_node, we_head, we_size, we_files, we_dirs;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [IW-1:0] par_wd;
  logic [IW:0]   head_wd, sib_wd;
  logic [63:0]   size_wd;
  logic [10:0]   files_wd;
  logic [9:0]    dirs_wd;
  logic          dflag_wd;

  assign cnt_m1 = count_r - CW'(1);

  always_comb begin
    rd_en     = 1'b0;
    we_node   = 1'b0;
    we_head   = 1'b0;
    we_size   = 1'b0;
    we_files  = 1'b0;
    we_dirs   = 1'b0;
    rd_addr   = walk_r;
    wr_addr   = count_r[IW-1:0];
    par_wd    = req_r.parent_index;
    head_wd   = '0;
    sib_wd    = '0;
    size_wd   = req_r.logical_size;
    files_wd  = {10'd0, ~req_r.is_directory};
    dirs_wd   = '0;
    dflag_wd  = req_r.is_directory;
    count_nxt = count_r;
    walk_nxt  = walk_r;
    unique case (cmd.op)
      patsa_pkg::OP_ADD_ROOT: begin
        we_node = 1'b1; we_head = 1'b1; we_size = 1'b1; we_files = 1'b1; we_dirs = 1'b1;
        par_wd  = '0;
        size_wd = '0;
        count_nxt = count_r + CW'(1);
      end
      patsa_pkg::OP_RD_HEAD: begin
        rd_en   = 1'b1;
        rd_addr = req_r.parent_index;
      end
      patsa_pkg::OP_ADD: begin
        we_node = 1'b1; we_head = 1'b1; we_size = 1'b1; we_files = 1'b1; we_dirs = 1'b1;
        sib_wd  = head_rd;
        count_nxt = count_r + CW'(1);
      end
      patsa_pkg::OP_LINK: begin
        we_head = 1'b1;
        wr_addr = req_r.parent_index;
        head_wd = {1'b1, cnt_m1[IW-1:0]};
      end
      patsa_pkg::OP_WALK_ZERO: walk_nxt = '0;
      patsa_pkg::OP_CLR_RD: rd_en = 1'b1;
      patsa_pkg::OP_CLR_WR: begin
        wr_addr  = walk_r;
        we_size  = dflag_rd;
        size_wd  = '0;
        we_files = 1'b1;
        files_wd = {10'd0, ~dflag_rd};
        we_dirs  = 1'b1;
        walk_nxt = walk_r + IW'(1);
      end
      patsa_pkg::OP_SUM_INIT: walk_nxt = cnt_m1[IW-1:0];
      patsa_pkg::OP_SUM_RD: rd_en = 1'b1;
      patsa_pkg::OP_SUM_RDP: begin
        rd_en   = 1'b1;
        rd_addr = par_rd;
      end
      patsa_pkg::OP_SUM_WR: begin
        wr_addr  = h_par_r;
        we_size  = 1'b1;
        we_files = 1'b1;
        we_dirs  = 1'b1;
        size_wd  = size_rd + h_size_r;
        files_wd = files_rd + h_files_r;
        dirs_wd  = dirs_rd + h_dirs_r + {9'd0, h_dflag_r};
        walk_nxt = walk_r - IW'(1);
      end
      patsa_pkg::OP_RD_NODE: begin
        rd_en   = 1'b1;
        rd_addr = req_r.read_index;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      par_rd   <= par_mem[rd_addr];
      head_rd  <= head_mem[rd_addr];
      sib_rd   <= sib_mem[rd_addr];
      size_rd  <= size_mem[rd_addr];
      files_rd <= files_mem[rd_addr];
      dirs_rd  <= dirs_mem[rd_addr];
      dflag_rd <= dflag_mem[rd_addr];
    end
    if (we_node) begin
      par_mem[wr_addr]   <= par_wd;
      sib_mem[wr_addr]   <= sib_wd;
      dflag_mem[wr_addr] <= dflag_wd;
    end
    if (we_head)  head_mem[wr_addr]  <= head_wd;
    if (we_size)  size_mem[wr_addr]  <= size_wd;
    if (we_files) files_mem[wr_addr] <= files_wd;
    if (we_dirs)  dirs_mem[wr_addr]  <= dirs_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) req_r <= in_word;
    if (cmd.op == patsa_pkg::OP_SUM_RDP) begin
      h_par_r   <= par_rd;
      h_size_r  <= size_rd;
      h_files_r <= files_rd;
      h_dirs_r  <= dirs_rd;
      h_dflag_r <= dflag_rd;
    end
    walk_r <= walk_nxt;
    if (cmd.load) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (cmd.res)
      patsa_pkg::RES_REJ: out_nxt.status = 1'b1;
      patsa_pkg::RES_OK: ;
      patsa_pkg::RES_ADD: out_nxt.new_index = cnt_m1[9:0];
      patsa_pkg::RES_READ: begin
        out_nxt.parent_out      = par_rd;
        out_nxt.has_parent      = (req_r.read_index != '0);
        out_nxt.first_child     = head_rd[IW-1:0];
        out_nxt.has_child       = head_rd[IW];
        out_nxt.next_sibling    = sib_rd[IW-1:0];
        out_nxt.has_sibling     = sib_rd[IW];
        out_nxt.size_out        = size_rd;
        out_nxt.file_count      = files_rd;
        out_nxt.directory_count = dirs_rd;
        out_nxt.is_dir_out      = dflag_rd;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.req        = patsa_pkg::req_t'(req_r.req_type);
    st.count_zero = (count_r == '0);
    st.full       = (count_r == CW'(patsa_pkg::MAX_NODES));
    st.par_ok     = ({1'b0, req_r.parent_index} < count_r);
    st.idx_ok     = ({1'b0, req_r.read_index} < count_r);
    st.walk_last  = ({1'b0, walk_r} == cnt_m1);
    st.walk_zero  = (walk_r == '0);
    st.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

@@ rtl/patsa_ctrl.sv @@
// Controller: sequences inserts, reads and the two aggregate passes.
// Depends on patsa_pkg.
`default_nettype none
module patsa_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  patsa_pkg::stat_t  st,
  output patsa_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_ADD, S_LINK, S_CLR_RD, S_CLR_WR,
    S_SUM_INIT, S_SUM_RD, S_SUM_RDP, S_SUM_WR, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  patsa_pkg::res_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= patsa_pkg::RES_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    cmd.cap   = 1'b0;
    cmd.op    = patsa_pkg::OP_NOP;
    cmd.load  = 1'b0;
    cmd.res   = res_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        state_nxt = S_FIN;
        unique case (st.req)
          patsa_pkg::REQ_ROOT: begin
            if (!st.count_zero) res_nxt = patsa_pkg::RES_REJ;
            else begin
              cmd.op  = patsa_pkg::OP_ADD_ROOT;
              res_nxt = patsa_pkg::RES_ADD;
            end
          end
          patsa_pkg::REQ_CHILD: begin
            if (!st.par_ok || st.full) res_nxt = patsa_pkg::RES_REJ;
            else begin
              cmd.op    = patsa_pkg::OP_RD_HEAD;
              res_nxt   = patsa_pkg::RES_ADD;
              state_nxt = S_ADD;
            end
          end
          patsa_pkg::REQ_AGG: begin
            res_nxt = patsa_pkg::RES_OK;
            if (!st.count_zero) begin
              cmd.op    = patsa_pkg::OP_WALK_ZERO;
              state_nxt = S_CLR_RD;
            end
          end
          patsa_pkg::REQ_READ: begin
            if (!st.idx_ok) res_nxt = patsa_pkg::RES_REJ;
            else begin
              cmd.op  = patsa_pkg::OP_RD_NODE;
              res_nxt = patsa_pkg::RES_READ;
            end
          end
          default: ;
        endcase
      end
      S_ADD: begin
        cmd.op    = patsa_pkg::OP_ADD;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        cmd.op    = patsa_pkg::OP_LINK;
        state_nxt = S_FIN;
      end
      S_CLR_RD: begin
        cmd.op    = patsa_pkg::OP_CLR_RD;
        state_nxt = S_CLR_WR;
      end
      S_CLR_WR: begin
        cmd.op    = patsa_pkg::OP_CLR_WR;
        state_nxt = st.walk_last ? S_SUM_INIT : S_CLR_RD;
      end
      S_SUM_INIT: begin
        cmd.op    = patsa_pkg::OP_SUM_INIT;
        state_nxt = S_SUM_RD;
      end
      S_SUM_RD: begin
        if (st.walk_zero) state_nxt = S_FIN;
        else begin
          cmd.op    = patsa_pkg::OP_SUM_RD;
          state_nxt = S_SUM_RDP;
        end
      end
      S_SUM_RDP: begin
        cmd.op    = patsa_pkg::OP_SUM_RDP;
        state_nxt = S_SUM_WR;
      end
      S_SUM_WR: begin
        cmd.op    = patsa_pkg::OP_SUM_WR;
        state_nxt = S_SUM_RD;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/parent_array_tree_size_aggregator.sv @@
// Parent-array file-tree size aggregator. One request at a time; each word
// gives one result word, held in an output register so the next request can
// be taken while it waits. A child add reads the parent's child head, writes
// the node, then relinks the head on the single write port. An aggregate runs
// a clear pass over every node, then a reverse walk over each non-root node
// for its read, parent read and parent write; an empty table skips both. The
// next word is taken in the idle state after the load, and a waiting result
// holds the load.
// Node tables are single-port-write memories and are not cleared at reset;
// only entries below the node count are read.
// Depends on patsa_pkg, patsa_ctrl and patsa_dp.
`default_nettype none
module parent_array_tree_size_aggregator (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  patsa_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  wire                   out_ready,
  output patsa_pkg::out_word_t  out_word
);

  patsa_pkg::cmd_t  cmd;
  patsa_pkg::stat_t st;

  patsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  patsa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

@@ rtl/patsa_checker.sv @@
// Port-level checker for the aggregator, bound to the top level.
// Depends on patsa_pkg and parent_array_tree_size_aggregator_macros.svh.
`default_nettype none
`include "parent_array_tree_size_aggregator_macros.svh"
module patsa_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input patsa_pkg::out_word_t out_word
);

  `PATSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `PATSA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `PATSA_ASSERT_NOW(a_reject_clean, clk, rst_n, out_valid && out_word.status, out_word.size_out == '0)
  `PATSA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_word))

endmodule

bind parent_array_tree_size_aggregator patsa_checker u_patsa_checker (.*);
`default_nettype wire
